@@ hw/rtl/bfpp_pkg.sv @@
package bfpp_pkg;

    // parse phase, which is also the reported byte role
    typedef enum logic [3:0] {
        PH_LEN_HI   = 4'd0,
        PH_LEN_LO   = 4'd1,
        PH_TGT_LEN  = 4'd2,
        PH_TGT_ADDR = 4'd3,
        PH_SRC_LEN  = 4'd4,
        PH_SRC_ADDR = 4'd5,
        PH_COUNT    = 4'd6,
        PH_NAME     = 4'd7,
        PH_TYPE     = 4'd8,
        PH_STRLEN   = 4'd9,
        PH_VALUE    = 4'd10,
        PH_DONE     = 4'd11
    } t_phase;

    // configuration register indexes
    localparam logic [1:0] CFG_MY_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_BCAST_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_WANTED_NAME   = 2'd2;

    localparam logic [15:0] MY_ADDRESS_RESET    = 16'h0000;
    localparam logic [15:0] BCAST_ADDRESS_RESET = 16'hFFFF;
    localparam logic [7:0]  WANTED_NAME_RESET   = 8'd99;

    // parameter type codes
    localparam logic [7:0] TYPE_CHAR    = 8'h63; // 'c'
    localparam logic [7:0] TYPE_BYTE_U  = 8'h42; // 'B'
    localparam logic [7:0] TYPE_BYTE_S  = 8'h62; // 'b'
    localparam logic [7:0] TYPE_INT_S   = 8'h69; // 'i'
    localparam logic [7:0] TYPE_INT_U   = 8'h49; // 'I'
    localparam logic [7:0] TYPE_LONG_S  = 8'h6C; // 'l'
    localparam logic [7:0] TYPE_LONG_U  = 8'h4C; // 'L'
    localparam logic [7:0] TYPE_STR     = 8'h73; // 's'
    localparam logic [7:0] TYPE_STR_LNG = 8'h53; // 'S'

    localparam logic [15:0] MIN_FRAME_LENGTH = 16'd3;

    typedef struct packed {
        logic [15:0] my_address;
        logic [15:0] bcast_address;
        logic [7:0]  wanted_name;
    } t_cfg;

    typedef struct packed {
        t_phase      byte_role;
        logic [7:0]  param_index;
        logic [15:0] value_offset;
        logic        is_match;
        logic        found;
        logic        for_me;
        logic        type_error;
        logic        frame_end;
    } t_result;

endpackage

@@ hw/rtl/bus_frame_parameter_parser.sv @@
// channel | direction | handshake              | payload
// cfg     | in        | i_cfg_we               | i_cfg_index, i_cfg_data
// in      | in        | i_in_valid / o_in_stall | i_data_byte, i_frame_start
// out     | out       | o_out_valid / i_out_stall | o_byte_role .. o_frame_end
//
// one byte per cycle sustained while the output is not stalled; each beat passes
// through the input register and then the result register
// the frame state advances as a beat moves from the input register to the
// result register, through a single pass of compare and counter logic
// synchronous active-low reset clears the frame state and loads the
// register defaults; no clearing pass
// a stall on the output only holds the input side once both registers are full
module bus_frame_parameter_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_byte_role,
    output logic [7:0]  o_param_index,
    output logic [15:0] o_value_offset,
    output logic        o_is_match,
    output logic        o_found,
    output logic        o_for_me,
    output logic        o_type_error,
    output logic        o_frame_end
);
    import bfpp_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_frame_start;

    // result register
    logic    r_out_valid;
    t_result r_result;

    t_result parse_result;
    logic    out_load;   // result register can take a new beat
    logic    advance;    // beat moves from input to result register
    logic    in_take;    // input beat accepted

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.my_address    <= MY_ADDRESS_RESET;
            r_cfg.bcast_address <= BCAST_ADDRESS_RESET;
            r_cfg.wanted_name   <= WANTED_NAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MY_ADDRESS:    r_cfg.my_address    <= i_cfg_data;
                CFG_BCAST_ADDRESS: r_cfg.bcast_address <= i_cfg_data;
                CFG_WANTED_NAME:   r_cfg.wanted_name   <= i_cfg_data[7:0];
                default: begin
                    // index beyond the register list: write ignored
                end
            endcase
        end
    end

    // input register, refilled whenever it empties or moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_data_byte   <= i_data_byte;
            r_frame_start <= i_frame_start;
        end
    end

    bfpp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_data_byte   (r_data_byte),
        .i_frame_start (r_frame_start),
        .i_cfg         (r_cfg),
        .o_result      (parse_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= parse_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_result.byte_role;
    assign o_param_index  = r_result.param_index;
    assign o_value_offset = r_result.value_offset;
    assign o_is_match     = r_result.is_match;
    assign o_found        = r_result.found;
    assign o_for_me       = r_result.for_me;
    assign o_type_error   = r_result.type_error;
    assign o_frame_end    = r_result.frame_end;

endmodule

@@ hw/rtl/bfpp_parser.sv @@
module bfpp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_start,
    input  bfpp_pkg::t_cfg    i_cfg,
    output bfpp_pkg::t_result o_result
);
    import bfpp_pkg::*;

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_decl, n_decl;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_tlen, n_tlen;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_done, n_done;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_slh, n_slh;
    logic [15:0] r_vc, n_vc;
    logic [15:0] r_cap, n_cap;
    logic        r_found, n_found;
    logic        r_error, n_error;
    logic        r_matching, n_matching;
    logic        r_ended, n_ended;

    logic [15:0] c_pos, c_decl, c_rem, c_vc, c_cap, rem_dec, str_len;
    t_phase      c_phase;
    logic [7:0]  c_tlen, c_total, c_done, c_type, c_slh, done_inc;
    logic        c_found, c_error, c_matching, c_ended;
    t_result     res;

    always_comb begin
        // a frame start clears the frame state before the byte is taken
        c_pos      = i_frame_start ? '0 : r_pos;
        c_decl     = i_frame_start ? '0 : r_decl;
        c_phase    = i_frame_start ? PH_LEN_HI : r_phase;
        c_tlen     = i_frame_start ? '0 : r_tlen;
        c_rem      = i_frame_start ? '0 : r_rem;
        c_total    = i_frame_start ? '0 : r_total;
        c_done     = i_frame_start ? '0 : r_done;
        c_type     = i_frame_start ? '0 : r_type;
        c_slh      = i_frame_start ? '0 : r_slh;
        c_vc       = i_frame_start ? '0 : r_vc;
        c_cap      = i_frame_start ? '0 : r_cap;
        c_found    = i_frame_start ? 1'b0 : r_found;
        c_error    = i_frame_start ? 1'b0 : r_error;
        c_matching = i_frame_start ? 1'b0 : r_matching;
        c_ended    = i_frame_start ? 1'b0 : r_ended;

        rem_dec  = (c_rem != '0) ? c_rem - 16'd1 : c_rem;
        done_inc = c_done + 8'd1;
        str_len  = (c_type == TYPE_STR_LNG) ? {c_slh, i_data_byte} : {8'd0, i_data_byte};

        n_pos      = (c_pos == 16'hFFFF) ? c_pos : c_pos + 16'd1;
        n_decl     = c_decl;
        n_phase    = c_phase;
        n_tlen     = c_tlen;
        n_rem      = c_rem;
        n_total    = c_total;
        n_done     = c_done;
        n_type     = c_type;
        n_slh      = c_slh;
        n_vc       = c_vc;
        n_cap      = c_cap;
        n_found    = c_found;
        n_error    = c_error;
        n_matching = c_matching;
        n_ended    = c_ended;

        res = '0;
        res.byte_role = PH_DONE;

        // target address is captured by position
        if (c_pos == 16'd3) n_cap[15:8] = i_data_byte;
        if (c_pos == 16'd4) n_cap[7:0]  = i_data_byte;

        if (!c_ended) begin
            res.byte_role = c_phase;
            unique case (c_phase)
                PH_LEN_HI: begin
                    n_decl  = {i_data_byte, 8'd0};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_decl  = {c_decl[15:8], i_data_byte};
                    if (n_decl < MIN_FRAME_LENGTH) n_decl = MIN_FRAME_LENGTH;
                    n_phase = PH_TGT_LEN;
                end
                PH_TGT_LEN: begin
                    n_tlen  = i_data_byte;
                    n_rem   = {8'd0, i_data_byte};
                    n_phase = (i_data_byte != '0) ? PH_TGT_ADDR : PH_SRC_LEN;
                end
                PH_TGT_ADDR: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) n_phase = PH_SRC_LEN;
                end
                PH_SRC_LEN: begin
                    n_rem   = {8'd0, i_data_byte};
                    n_phase = (i_data_byte != '0) ? PH_SRC_ADDR : PH_COUNT;
                end
                PH_SRC_ADDR: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    n_total = i_data_byte;
                    n_done  = '0;
                    n_phase = (i_data_byte != '0) ? PH_NAME : PH_DONE;
                end
                PH_NAME: begin
                    res.param_index = c_done;
                    n_matching = 1'b0;
                    if (!c_found && i_data_byte == i_cfg.wanted_name) begin
                        n_found    = 1'b1;
                        n_matching = 1'b1;
                    end
                    res.is_match = n_matching;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    res.param_index = c_done;
                    res.is_match    = c_matching;
                    n_type = i_data_byte;
                    n_vc   = '0;
                    if (i_data_byte == TYPE_CHAR || i_data_byte == TYPE_BYTE_U ||
                        i_data_byte == TYPE_BYTE_S) begin
                        n_rem   = 16'd1;
                        n_phase = PH_VALUE;
                    end else if (i_data_byte == TYPE_INT_S || i_data_byte == TYPE_INT_U) begin
                        n_rem   = 16'd2;
                        n_phase = PH_VALUE;
                    end else if (i_data_byte == TYPE_LONG_S ||
                                 i_data_byte == TYPE_LONG_U) begin
                        n_rem   = 16'd4;
                        n_phase = PH_VALUE;
                    end else if (i_data_byte == TYPE_STR || i_data_byte == TYPE_STR_LNG) begin
                        n_phase = PH_STRLEN;
                    end else begin
                        n_error    = 1'b1;
                        n_matching = 1'b0;
                        n_phase    = PH_DONE;
                    end
                end
                PH_STRLEN: begin
                    res.param_index  = c_done;
                    res.value_offset = c_vc;
                    res.is_match     = c_matching;
                    if (c_type == TYPE_STR_LNG && c_vc == '0) begin
                        n_slh = i_data_byte;
                        n_vc  = 16'd1;
                    end else begin
                        n_vc = '0;
                        if (str_len == '0) begin
                            n_done     = done_inc;
                            n_matching = 1'b0;
                            n_phase    = (done_inc == c_total) ? PH_DONE : PH_NAME;
                        end else begin
                            n_rem   = str_len;
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    res.param_index  = c_done;
                    res.value_offset = c_vc;
                    res.is_match     = c_matching;
                    n_vc  = c_vc + 16'd1;
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_done     = done_inc;
                        n_matching = 1'b0;
                        n_phase    = (done_inc == c_total) ? PH_DONE : PH_NAME;
                    end
                end
                default: begin
                    res.byte_role = PH_DONE;
                end
            endcase
            if (c_pos >= 16'd2 && ({1'b0, c_pos} + 17'd1) == {1'b0, n_decl}) begin
                res.frame_end = 1'b1;
                n_ended       = 1'b1;
            end
        end

        if (c_pos >= 16'd4) begin
            res.for_me = (n_cap == i_cfg.bcast_address) ||
                         (n_tlen == 8'd2 && n_cap == i_cfg.my_address);
        end
        res.found      = n_found;
        res.type_error = n_error;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_decl     <= '0;
            r_phase    <= PH_LEN_HI;
            r_tlen     <= '0;
            r_rem      <= '0;
            r_total    <= '0;
            r_done     <= '0;
            r_type     <= '0;
            r_slh      <= '0;
            r_vc       <= '0;
            r_cap      <= '0;
            r_found    <= 1'b0;
            r_error    <= 1'b0;
            r_matching <= 1'b0;
            r_ended    <= 1'b0;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_decl     <= n_decl;
            r_phase    <= n_phase;
            r_tlen     <= n_tlen;
            r_rem      <= n_rem;
            r_total    <= n_total;
            r_done     <= n_done;
            r_type     <= n_type;
            r_slh      <= n_slh;
            r_vc       <= n_vc;
            r_cap      <= n_cap;
            r_found    <= n_found;
            r_error    <= n_error;
            r_matching <= n_matching;
            r_ended    <= n_ended;
        end
    end

endmodule
